// ----- hw/rtl/pefga_pkg.sv -----
`timescale 1ns / 1ps
package pefga_pkg;
  localparam int NumTypesDefault    = 4;
  localparam int NumFeaturesDefault = 16;
  localparam int AccDepth           = 64;
  localparam int IdxW               = 6;
  localparam int AccW               = 48;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = -32'sh7FFFFFFF - 32'sd1;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh800000000000;
  localparam logic signed [31:0] INV_LN2_Q16 = 32'sd94548;
  localparam logic signed [31:0] LN2_Q16     = 32'sd45426;
  localparam logic [0:0] KIND_PAIR = 1'b0;
  localparam logic [0:0] KIND_READ = 1'b1;

  // Datapath steps; the controller walks them in order, and a read request steps from OP_ARD straight to OP_CLR.
  typedef enum logic [4:0] {
    OP_S0, OP_S1, OP_S2, OP_SSUM,
    OP_X, OP_EXPK, OP_EXPR, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_ESCL,
    OP_SDS, OP_WE, OP_WED, OP_BUFF, OP_SW, OP_NET, OP_Q, OP_AINC, OP_EINC,
    OP_ARD, OP_ACC, OP_CLR, OP_NOP
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  // Saturate a wide signed value to 32 bits and flag the clip.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v, output logic c);
    c = 1'b0;
    if (v > 66'sd2147483647) begin
      c = 1'b1;
      sat32 = Q_MAX;
    end else if (v < -66'sd2147483648) begin
      c = 1'b1;
      sat32 = Q_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage

// ----- hw/rtl/pair_exp_feature_grad_accum_unit.sv -----
`timescale 1ns / 1ps
// Pair exponential-feature gradient accumulator in Q16.16. A kind 0 request
// computes the net-gradient part and adds two products into the per-entry
// alpha and embedding accumulators; a kind 1 request reads one entry and
// clears it. One shared multiplier is stepped by a controller through the
// datapath steps in order. Requests are taken one at a time.
module pair_exp_feature_grad_accum_unit
  import pefga_pkg::*;
#(
  parameter int NUM_TYPES    = NumTypesDefault,
  parameter int NUM_FEATURES = NumFeaturesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [IdxW-1:0]        coef_index,
  input  logic signed [31:0]     distance_feature,
  input  logic signed [31:0]     decay_rate,
  input  logic signed [31:0]     embed_weight,
  input  logic signed [31:0]     net_deriv,
  input  logic signed [31:0]     grad_diff_x,
  input  logic signed [31:0]     grad_diff_y,
  input  logic signed [31:0]     grad_diff_z,
  input  logic signed [31:0]     deriv_x,
  input  logic signed [31:0]     deriv_y,
  input  logic signed [31:0]     deriv_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     net_grad_part,
  output logic signed [AccW-1:0] alpha_grad_total,
  output logic signed [AccW-1:0] embed_grad_total,
  output logic                   saturated
);
  logic busy, done, in_fire, out_fire, kind_hold;
  cmd_t cmd;

  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = done;
  assign out_fire  = out_valid && out_ready;

  // The controller needs the request kind after acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) kind_hold <= kind;
  end

  pefga_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .kind_in(in_fire ? kind : kind_hold),
    .out_fire(out_fire), .busy(busy), .done(done), .cmd(cmd)
  );

  pefga_dp #(.NUM_TYPES(NUM_TYPES), .NUM_FEATURES(NUM_FEATURES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(kind), .coef_index(coef_index),
    .distance_feature(distance_feature), .decay_rate(decay_rate),
    .embed_weight(embed_weight), .net_deriv(net_deriv),
    .grad_diff_x(grad_diff_x), .grad_diff_y(grad_diff_y),
    .grad_diff_z(grad_diff_z), .deriv_x(deriv_x), .deriv_y(deriv_y),
    .deriv_z(deriv_z), .net_grad_part(net_grad_part),
    .alpha_grad_total(alpha_grad_total), .embed_grad_total(embed_grad_total),
    .saturated(saturated)
  );

`ifndef SYNTHESIS
  // No request is taken while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request accepted while busy");
  // A pending result stays valid, with alpha_grad_total unchanged, until it is taken.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alpha_grad_total))
    else $error("result dropped or changed");
`endif
endmodule

// ----- hw/rtl/pefga_ctrl.sv -----
`timescale 1ns / 1ps
module pefga_ctrl
  import pefga_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic kind_in,
  input  logic out_fire,
  output logic busy,
  output logic done,
  output cmd_t cmd
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.load   = in_fire;
    cmd.op     = OP_NOP;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_RUN;
          op_next    = (kind_in == KIND_READ) ? OP_ARD : OP_S0;
        end
      end
      ST_RUN: begin
        cmd.op = op;
        if (op == OP_ACC || op == OP_CLR) begin
          state_next = ST_OUT;
        end else if (op == OP_ARD) begin
          op_next = kind_in == KIND_READ ? OP_CLR : OP_ACC;
        end else begin
          op_next = op_t'(op + 5'd1);
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_S0;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_OUT;
endmodule

// ----- hw/rtl/pefga_dp.sv -----
`timescale 1ns / 1ps
module pefga_dp
  import pefga_pkg::*;
#(
  parameter int NUM_TYPES    = NumTypesDefault,
  parameter int NUM_FEATURES = NumFeaturesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic                   kind,
  input  logic [IdxW-1:0]        coef_index,
  input  logic signed [31:0]     distance_feature,
  input  logic signed [31:0]     decay_rate,
  input  logic signed [31:0]     embed_weight,
  input  logic signed [31:0]     net_deriv,
  input  logic signed [31:0]     grad_diff_x,
  input  logic signed [31:0]     grad_diff_y,
  input  logic signed [31:0]     grad_diff_z,
  input  logic signed [31:0]     deriv_x,
  input  logic signed [31:0]     deriv_y,
  input  logic signed [31:0]     deriv_z,
  output logic signed [31:0]     net_grad_part,
  output logic signed [AccW-1:0] alpha_grad_total,
  output logic signed [AccW-1:0] embed_grad_total,
  output logic                   saturated
);
  localparam int Entries = NUM_TYPES * NUM_FEATURES;

  logic signed [AccW-1:0] alpha_mem [AccDepth];
  logic signed [AccW-1:0] embed_mem [AccDepth];
  logic [AccDepth-1:0]    vld;

  logic               kind_r;
  logic [IdxW-1:0]    idx;
  logic               idx_ok;
  logic signed [31:0] ds, alpha, w, nd;
  logic signed [31:0] gd [3];
  logic signed [31:0] dv [3];
  logic signed [47:0] ssum;
  logic signed [31:0] s, x, e, onepx, twopx, sds, t, buff, q, ainc, einc, net;
  logic signed [47:0] k;
  logic signed [47:0] r;
  logic signed [47:0] p;
  logic signed [AccW-1:0] ard, erd;
  logic               clip;

  logic signed [31:0] mul_a, mul_b, mr;
  logic signed [63:0] prod;
  logic               mc;
  logic signed [65:0] addv;
  logic signed [31:0] sv, onev, twov;
  logic               sc, c1, c2;
  logic signed [63:0] kx;
  logic signed [31:0] pa, ra;
  logic signed [63:0] pr;
  logic signed [47:0] pn;
  logic signed [63:0] eshift;
  logic signed [31:0] esat;
  logic               ec;
  logic signed [48:0] asum, esum;
  logic signed [AccW-1:0] anew, enew;
  logic               ac, ecl;

  assign idx_ok = 32'(idx) < Entries;

  // One shared Q16.16 multiplier.
  always_comb begin
    mul_a = s;
    mul_b = w;
    case (cmd.op)
      OP_S0:   begin mul_a = gd[0]; mul_b = dv[0]; end
      OP_S1:   begin mul_a = gd[1]; mul_b = dv[1]; end
      OP_S2:   begin mul_a = gd[2]; mul_b = dv[2]; end
      OP_X:    begin mul_a = alpha; mul_b = ds; end
      OP_SDS:  begin mul_a = e;     mul_b = onepx; end
      OP_WE:   begin mul_a = w;     mul_b = e; end
      OP_WED:  begin mul_a = t;     mul_b = ds; end
      OP_BUFF: begin mul_a = t;     mul_b = twopx; end
      OP_SW:   begin mul_a = s;     mul_b = w; end
      OP_NET:  begin mul_a = t;     mul_b = sds; end
      OP_Q:    begin mul_a = s;     mul_b = nd; end
      OP_AINC: begin mul_a = q;     mul_b = buff; end
      OP_EINC: begin mul_a = q;     mul_b = sds; end
      default: ;
    endcase
    prod = mul_a * mul_b;
    mr   = sat32(66'(prod >>> 16), mc);
    addv = 66'(ssum);
    sv   = sat32(addv, sc);
    onev = sat32(66'(x) + 66'sd65536, c1);
    twov = sat32(66'(x) + 66'sd131072, c2);
    kx   = 64'(x) * 64'(INV_LN2_Q16);
    // The reduced argument and the polynomial both stay well inside 32 bits.
    pa   = p[31:0];
    ra   = r[31:0];
    pr   = pa * ra;
    pn   = 48'(pr >>> 16);
    eshift = 64'(p) <<< k[3:0];
    esat = sat32(66'(eshift), ec);
    asum = 49'(ard) + 49'(ainc);
    esum = 49'(erd) + 49'(einc);
    ac   = asum > 49'(ACC_MAX) || asum < 49'(ACC_MIN);
    ecl  = esum > 49'(ACC_MAX) || esum < 49'(ACC_MIN);
    anew = asum > 49'(ACC_MAX) ? ACC_MAX : asum < 49'(ACC_MIN) ? ACC_MIN : asum[47:0];
    enew = esum > 49'(ACC_MAX) ? ACC_MAX : esum < 49'(ACC_MIN) ? ACC_MIN : esum[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.op == OP_ACC && idx_ok) begin
      vld[idx] <= 1'b1;
    end else if (cmd.op == OP_CLR && idx_ok) begin
      vld[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      idx    <= coef_index;
      ds     <= distance_feature;
      alpha  <= decay_rate;
      w      <= embed_weight;
      nd     <= net_deriv;
      gd[0]  <= grad_diff_x;
      gd[1]  <= grad_diff_y;
      gd[2]  <= grad_diff_z;
      dv[0]  <= deriv_x;
      dv[1]  <= deriv_y;
      dv[2]  <= deriv_z;
      ssum   <= '0;
      clip   <= 1'b0;
    end
    case (cmd.op)
      OP_S0, OP_S1, OP_S2: ssum <= ssum + 48'(prod >>> 17);
      OP_SSUM: begin s <= sv; clip <= clip | sc; end
      OP_X:    begin x <= mr; clip <= clip | mc; end
      OP_EXPK: begin
        k <= 48'(kx >>> 32);
        onepx <= onev;
        twopx <= twov;
        clip <= clip | c1 | c2;
      end
      OP_EXPR: begin
        r <= 48'(x) - k * 48'(LN2_Q16);
        p <= 48'sd546;
      end
      OP_P1: p <= 48'sd2731 + pn;
      OP_P2: p <= 48'sd10923 + pn;
      OP_P3: p <= 48'sd32768 + pn;
      OP_P4: p <= 48'sd65536 + pn;
      OP_P5: begin
        if (48'sd65536 + pn < 0) p <= '0;
        else p <= 48'sd65536 + pn;
      end
      OP_ESCL: begin
        if (k > 48'sd15) begin
          e <= Q_MAX;
          clip <= 1'b1;
        end else if (k >= 0) begin
          e <= esat;
          clip <= clip | ec;
        end else if (k < -48'sd62) begin
          e <= '0;
        end else begin
          e <= 32'(p >>> (-k));
        end
      end
      OP_SDS:  begin sds <= mr; clip <= clip | mc; end
      OP_WE, OP_WED, OP_SW: begin t <= mr; clip <= clip | mc; end
      OP_BUFF: begin buff <= mr; clip <= clip | mc; end
      OP_NET:  begin net <= mr; clip <= clip | mc; end
      OP_Q:    begin q <= mr; clip <= clip | mc; end
      // Increment clips only count when the entry exists.
      OP_AINC: begin
        ainc <= mr;
        if (idx_ok) clip <= clip | mc;
      end
      OP_EINC: begin
        einc <= mr;
        if (idx_ok) clip <= clip | mc;
      end
      OP_ARD: begin
        ard <= vld[idx] ? alpha_mem[idx] : '0;
        erd <= vld[idx] ? embed_mem[idx] : '0;
      end
      OP_ACC: begin
        if (idx_ok) begin
          alpha_mem[idx] <= anew;
          embed_mem[idx] <= enew;
          clip <= clip | ac | ecl;
        end
      end
      default: ;
    endcase
  end

  assign net_grad_part    = kind_r ? '0 : net;
  assign alpha_grad_total = !idx_ok ? '0 : kind_r ? ard : anew;
  assign embed_grad_total = !idx_ok ? '0 : kind_r ? erd : enew;
  assign saturated        = kind_r ? 1'b0 : clip;
endmodule

// ----- tb/sv/pair_exp_feature_grad_accum_unit_test.sv -----
`timescale 1ns / 1ps
module pair_exp_feature_grad_accum_unit_test;
  import pefga_pkg::*;

  localparam int NumEntries = NumTypesDefault * NumFeaturesDefault;
  localparam int RandomRequests = 1700;
  localparam int DrainCycles = 40;
  localparam int IdleLimit = 5000;

  // One request as presented on the input ports.
  typedef struct packed {
    logic [0:0]         kind;
    logic [IdxW-1:0]    idx;
    logic signed [31:0] ds;
    logic signed [31:0] alpha;
    logic signed [31:0] w;
    logic signed [31:0] nd;
    logic signed [31:0] gx, gy, gz;
    logic signed [31:0] dx, dy, dz;
  } grad_req_t;

  // One result as seen on the output ports.
  typedef struct packed {
    logic signed [31:0]     net;
    logic signed [AccW-1:0] atot;
    logic signed [AccW-1:0] etot;
    logic                   clip;
  } grad_res_t;

  // Directed row: the request, and optionally a typed-in expected result.
  typedef struct packed {
    grad_req_t req;
    logic      fixed;
    grad_res_t res;
  } drow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [IdxW-1:0] coef_index = '0;
  logic signed [31:0] distance_feature = '0, decay_rate = '0, embed_weight = '0;
  logic signed [31:0] net_deriv = '0;
  logic signed [31:0] grad_diff_x = '0, grad_diff_y = '0, grad_diff_z = '0;
  logic signed [31:0] deriv_x = '0, deriv_y = '0, deriv_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] net_grad_part;
  logic signed [AccW-1:0] alpha_grad_total, embed_grad_total;
  logic saturated;

  pair_exp_feature_grad_accum_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .coef_index(coef_index),
    .distance_feature(distance_feature), .decay_rate(decay_rate),
    .embed_weight(embed_weight), .net_deriv(net_deriv),
    .grad_diff_x(grad_diff_x), .grad_diff_y(grad_diff_y), .grad_diff_z(grad_diff_z),
    .deriv_x(deriv_x), .deriv_y(deriv_y), .deriv_z(deriv_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .net_grad_part(net_grad_part), .alpha_grad_total(alpha_grad_total),
    .embed_grad_total(embed_grad_total), .saturated(saturated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state: its own copy of both accumulator banks.
  logic signed [AccW-1:0] alpha_bank [AccDepth];
  logic signed [AccW-1:0] embed_bank [AccDepth];
  grad_res_t pending_results[$];

  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  int pair_count = 0, read_count = 0, clip_count = 0;
  bit sender_done = 1'b0;
  bit long_stall = 1'b0;

  // Arithmetic shift right rounds toward minus infinity, as the block does.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit c);
    if (v > 128'sd2147483647) begin
      c = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      c = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               inout bit c);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return clamp32(p >>> 16, c);
  endfunction

  function automatic logic signed [31:0] fxexp(input logic signed [31:0] x, inout bit c);
    logic signed [127:0] k, r, p;
    int coeffs [5];
    coeffs = '{2731, 10923, 32768, 65536, 65536};
    k = (128'(x) * 128'sd94548) >>> 32;
    r = 128'(x) - k * 128'sd45426;
    p = 128'sd546;
    for (int i = 0; i < 5; i++) p = 128'(coeffs[i]) + ((p * r) >>> 16);
    if (p < 0) p = 0;
    if (k > 15) begin
      c = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (k >= 0) return clamp32(p <<< k, c);
    if (k < -62) return 32'sd0;
    return 32'(p >>> (-k));
  endfunction

  function automatic logic signed [AccW-1:0] acc_sum(input logic signed [AccW-1:0] a,
                                                     input logic signed [31:0] inc,
                                                     inout bit c);
    logic signed [63:0] s;
    s = 64'(a) + 64'(inc);
    if (s > 64'(ACC_MAX)) begin
      c = 1'b1;
      return ACC_MAX;
    end
    if (s < 64'(ACC_MIN)) begin
      c = 1'b1;
      return ACC_MIN;
    end
    return s[AccW-1:0];
  endfunction

  // Works out the result of one request and updates the predicted banks.
  function automatic grad_res_t predict_gradient(input grad_req_t q);
    grad_res_t o;
    bit c;
    bit in_range;
    logic signed [127:0] s;
    logic signed [31:0] sv, x, e, onepx, twopx, sds, buff, qq;
    c = 1'b0;
    o = '0;
    in_range = q.idx < NumEntries;
    if (q.kind == KIND_READ) begin
      if (in_range) begin
        o.atot = alpha_bank[q.idx];
        o.etot = embed_bank[q.idx];
        alpha_bank[q.idx] = '0;
        embed_bank[q.idx] = '0;
      end
      return o;
    end
    s = ((128'(q.gx) * 128'(q.dx)) >>> 17) + ((128'(q.gy) * 128'(q.dy)) >>> 17)
      + ((128'(q.gz) * 128'(q.dz)) >>> 17);
    sv = clamp32(s, c);
    x = fxmul(q.alpha, q.ds, c);
    e = fxexp(x, c);
    onepx = clamp32(128'sd65536 + 128'(x), c);
    twopx = clamp32(128'sd131072 + 128'(x), c);
    sds = fxmul(e, onepx, c);
    buff = fxmul(fxmul(fxmul(q.w, e, c), q.ds, c), twopx, c);
    o.net = fxmul(fxmul(sv, q.w, c), sds, c);
    qq = fxmul(sv, q.nd, c);
    if (in_range) begin
      alpha_bank[q.idx] = acc_sum(alpha_bank[q.idx], fxmul(qq, buff, c), c);
      embed_bank[q.idx] = acc_sum(embed_bank[q.idx], fxmul(qq, sds, c), c);
      o.atot = alpha_bank[q.idx];
      o.etot = embed_bank[q.idx];
    end
    o.clip = c;
    return o;
  endfunction

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    endcase
  endfunction

  // Mostly pair requests on small values so the exponent stays in range,
  // with reads mixed in to drain entries, plus some wide noise.
  function automatic grad_req_t random_request();
    grad_req_t q;
    q.kind = ($urandom_range(0, 5) == 0) ? KIND_READ : KIND_PAIR;
    q.idx = ($urandom_range(0, 9) == 0) ? IdxW'($urandom()) :
            IdxW'($urandom_range(0, NumEntries - 1));
    q.ds = pick_q16();
    q.alpha = pick_q16();
    q.w = pick_q16();
    q.nd = pick_q16();
    q.gx = pick_q16();
    q.gy = pick_q16();
    q.gz = pick_q16();
    q.dx = pick_q16();
    q.dy = pick_q16();
    q.dz = pick_q16();
    return q;
  endfunction

  // Drives one request and holds it until the block takes it. Valid drops
  // during a gap so an accepted request is never offered twice.
  task automatic offer_request(input grad_req_t q, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= q.kind;
    coef_index <= q.idx;
    distance_feature <= q.ds;
    decay_rate <= q.alpha;
    embed_weight <= q.w;
    net_deriv <= q.nd;
    grad_diff_x <= q.gx;
    grad_diff_y <= q.gy;
    grad_diff_z <= q.gz;
    deriv_x <= q.dx;
    deriv_y <= q.dy;
    deriv_z <= q.dz;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (q.kind == KIND_READ) read_count++;
    else pair_count++;
  endtask

  task automatic release_valid();
    in_valid <= 1'b0;
  endtask

  function automatic grad_req_t make_req(input logic [0:0] k, input int idx,
                                         input logic signed [31:0] v);
    grad_req_t q;
    q = '{k, IdxW'(idx), v, v, v, v, v, v, v, v, v, v};
    return q;
  endfunction

  drow_t directed_rows [$];

  task automatic build_directed();
    grad_req_t q;
    // Reads after reset see zero everywhere.
    directed_rows.push_back('{make_req(KIND_READ, 0, 0), 1'b1, '0});
    directed_rows.push_back('{make_req(KIND_READ, NumEntries - 1, 0), 1'b1, '0});
    // An all-zero pair request: S is zero, so nothing moves.
    directed_rows.push_back('{make_req(KIND_PAIR, 3, 0), 1'b1, '0});
    // The last entry: a pair request with every field at one, then its read-back.
    q = make_req(KIND_PAIR, 63, 32'sh10000);
    directed_rows.push_back('{q, 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_READ, 63, 0), 1'b0, '0});
    // Extremes of every field, which saturate the products and the exponent.
    directed_rows.push_back('{make_req(KIND_PAIR, 5, 32'sh7FFFFFFF), 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_PAIR, 5, 32'sh80000000), 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_READ, 5, 0), 1'b0, '0});
    // Exponent overflow with moderate values, and deep underflow.
    q = make_req(KIND_PAIR, 7, 32'sh10000);
    q.ds = 32'sh000C0000;
    q.alpha = 32'sh00010000;
    directed_rows.push_back('{q, 1'b0, '0});
    q.alpha = 32'shFFFF0000;
    q.ds = 32'sh00640000;
    directed_rows.push_back('{q, 1'b0, '0});
    // Repeated hits on one entry drive the accumulator toward its rail.
    q = make_req(KIND_PAIR, 9, 32'sh7FFFFFFF);
    q.alpha = 32'sh00001000;
    q.ds = 32'sh00001000;
    for (int i = 0; i < 6; i++) directed_rows.push_back('{q, 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_READ, 9, 0), 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_READ, 9, 0), 1'b1, '0});
    // One ordinary pair followed by its read-back.
    q = make_req(KIND_PAIR, 12, 32'sh00018000);
    q.alpha = 32'shFFFF8000;
    directed_rows.push_back('{q, 1'b0, '0});
    directed_rows.push_back('{make_req(KIND_READ, 12, 0), 1'b0, '0});
  endtask

  // Sender: directed table, then random requests with pauses.
  initial begin
    grad_res_t exp_res;
    grad_req_t q;
    for (int i = 0; i < AccDepth; i++) begin
      alpha_bank[i] = '0;
      embed_bank[i] = '0;
    end
    build_directed();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      exp_res = predict_gradient(directed_rows[i].req);
      if (directed_rows[i].fixed && exp_res !== directed_rows[i].res) begin
        errors++;
        $display("%t table row %0d expected %h predictor gives %h", $time, i,
                 directed_rows[i].res, exp_res);
      end
      if (directed_rows[i].fixed) exp_res = directed_rows[i].res;
      pending_results.push_back(exp_res);
      offer_request(directed_rows[i].req, $urandom_range(0, 3));
    end
    for (int n = 0; n < RandomRequests; n++) begin
      // Partway through, stall until everything is back.
      if (n == RandomRequests / 2) begin
        release_valid();
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (n == RandomRequests / 4) long_stall = 1'b1;
      q = random_request();
      pending_results.push_back(predict_gradient(q));
      // Streaks of back-to-back requests with valid held high throughout.
      offer_request(q, (n % 64 < 16) ? 0 : $urandom_range(0, 3));
    end
    release_valid();
    sender_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (long_stall) begin
        long_stall = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    grad_res_t want;
    if (!rst && out_valid && out_ready) begin
      received++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%t result with nothing expected: net=%h", $time, net_grad_part);
      end else begin
        want = pending_results.pop_front();
        if (want.clip) clip_count++;
        if (net_grad_part !== want.net) begin
          errors++;
          $display("%t net_grad_part expected %h got %h", $time, want.net, net_grad_part);
        end
        if (alpha_grad_total !== want.atot) begin
          errors++;
          $display("%t alpha_grad_total expected %h got %h", $time, want.atot,
                   alpha_grad_total);
        end
        if (embed_grad_total !== want.etot) begin
          errors++;
          $display("%t embed_grad_total expected %h got %h", $time, want.etot,
                   embed_grad_total);
        end
        if (saturated !== want.clip) begin
          errors++;
          $display("%t saturated expected %b got %b", $time, want.clip, saturated);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%t no progress, %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d requests (%0d pair, %0d read) and checked %0d results,",
             sent, pair_count, read_count, received);
    $display("%0d of them clipped, under random and long output stalls.", clip_count);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
